FILE: design/ppa_pkg.sv
package ppa_pkg;

  // sizing
  localparam int NUM_KEYS   = 12;
  localparam int ECHO_DEPTH = 51;
  localparam int KEY_LIMIT  = (NUM_KEYS < 12) ? NUM_KEYS : 12;
  localparam int KEY_W      = 4;
  localparam int ACC_W      = 32;
  localparam int SUM_W      = $clog2(NUM_KEYS + 1) + 8;
  localparam int SAMP_W     = 16;
  localparam int TOT_W      = 21;
  localparam int MAG_W      = TOT_W - 1;
  localparam int QUOT_W     = 17;
  localparam int CYC_W      = $clog2(NUM_KEYS + 8);

  // sequencer events, counted from the first issue cycle
  localparam int EV_SHAPE   = NUM_KEYS + 4;
  localparam int EV_ECHO    = NUM_KEYS + 5;
  localparam int EV_DIVIDE  = NUM_KEYS + 6;
  localparam int EV_LAST    = NUM_KEYS + 7;

  // keys that can be held
  localparam logic [11:0] KEY_LIMIT_MASK = 12'((13'd1 << KEY_LIMIT) - 13'd1);

  // arithmetic constants
  localparam logic [31:0] STEP_SCALE  = 32'd195225;
  localparam logic [32:0] DIV10_RECIP = 33'h0_CCCC_CCCD;
  localparam logic [19:0] TOT_RECIP   = 20'hCCCCD;

  // echo taps, read before the shift (they become entries 45, 35 and 20)
  localparam int TAP_A = 44;
  localparam int TAP_B = 34;
  localparam int TAP_C = 19;

  // register map
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_VOLUME       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OCTAVE       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAVEFORM     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILT_SEL     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_INDEX = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REVERB_ON    = 3'd5;

  // field codes
  localparam logic [1:0] WAVE_TRI  = 2'd1;
  localparam logic [1:0] WAVE_SQR  = 2'd2;
  localparam logic [1:0] FILT_LOW  = 2'd1;
  localparam logic [1:0] FILT_HIGH = 2'd2;

  typedef struct packed {
    logic [4:0] volume;
    logic [3:0] octave;
    logic [1:0] waveform;
    logic [1:0] filt_sel;
    logic [3:0] filter_index;
    logic       reverb_on;
  } cfg_t;

  // base note step of each key
  function automatic logic [8:0] base_step(input logic [KEY_W-1:0] key);
    logic [8:0] r;
    case (key)
      4'd0:    r = 9'd262;
      4'd1:    r = 9'd277;
      4'd2:    r = 9'd294;
      4'd3:    r = 9'd311;
      4'd4:    r = 9'd330;
      4'd5:    r = 9'd349;
      4'd6:    r = 9'd370;
      4'd7:    r = 9'd392;
      4'd8:    r = 9'd415;
      4'd9:    r = 9'd440;
      4'd10:   r = 9'd466;
      4'd11:   r = 9'd494;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // filter weight, a ramp clamped to 1..10; row already limited to 0..9
  function automatic logic [3:0] filter_weight(input logic       high_pass,
                                               input logic [3:0] row,
                                               input logic [KEY_W-1:0] key);
    logic signed [6:0] w;
    if (high_pass) begin
      w = 7'sd7 + $signed({3'b000, key}) - $signed({3'b000, row});
    end else begin
      w = 7'sd18 - $signed({3'b000, key}) - $signed({3'b000, row});
    end
    if (w < 7'sd1) begin
      w = 7'sd1;
    end else if (w > 7'sd10) begin
      w = 7'sd10;
    end
    return w[3:0];
  endfunction

endpackage

FILE: design/ppa_regs.sv
module ppa_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ppa_pkg::cfg_t               cfg_o
);
  import ppa_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume       <= 5'd12;
      cfg_q.octave       <= 4'd4;
      cfg_q.waveform     <= 2'd0;
      cfg_q.filt_sel     <= 2'd0;
      cfg_q.filter_index <= 4'd0;
      cfg_q.reverb_on    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_VOLUME:       cfg_q.volume       <= pwdata[4:0];
        REG_OCTAVE:       cfg_q.octave       <= pwdata[3:0];
        REG_WAVEFORM:     cfg_q.waveform     <= pwdata[1:0];
        REG_FILT_SEL:     cfg_q.filt_sel     <= pwdata[1:0];
        REG_FILTER_INDEX: cfg_q.filter_index <= pwdata[3:0];
        REG_REVERB_ON:    cfg_q.reverb_on    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_VOLUME:       prdata = {27'd0, cfg_q.volume};
      REG_OCTAVE:       prdata = {28'd0, cfg_q.octave};
      REG_WAVEFORM:     prdata = {30'd0, cfg_q.waveform};
      REG_FILT_SEL:     prdata = {30'd0, cfg_q.filt_sel};
      REG_FILTER_INDEX: prdata = {28'd0, cfg_q.filter_index};
      REG_REVERB_ON:    prdata = {31'd0, cfg_q.reverb_on};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/ppa_step.sv
module ppa_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppa_pkg::cfg_t              cfg_i,
  input  logic                       live_i,
  input  logic                       act_i,
  input  logic [ppa_pkg::KEY_W-1:0]  key_i,
  output logic                       live_o,
  output logic                       act_o,
  output logic [ppa_pkg::ACC_W-1:0]  step_o
);
  import ppa_pkg::*;

  logic             p1_live_q, p1_act_q;
  logic [KEY_W-1:0] p1_key_q;
  logic [ACC_W-1:0] p1_step_q;
  logic             p2_live_q, p2_act_q, p2_filt_q;
  logic [ACC_W-1:0] p2_step_q;
  logic [28:0]      p2_quot_q;
  logic [3:0]       p2_wt_q;
  logic             p3_live_q, p3_act_q;
  logic [ACC_W-1:0] p3_step_q;

  logic [ACC_W-1:0] oct_step;
  logic [65:0]      recip_prod;
  logic [3:0]       row;
  logic             filt_on;

  // octave shift of the base step
  always_comb begin
    oct_step = {23'd0, base_step(key_i)};
    if (cfg_i.octave < 4'd4) begin
      oct_step = oct_step >> (4'd4 - cfg_i.octave);
    end else begin
      oct_step = oct_step << (cfg_i.octave - 4'd4);
    end
  end

  assign filt_on    = (cfg_i.filt_sel == FILT_LOW) || (cfg_i.filt_sel == FILT_HIGH);
  assign row        = (cfg_i.filter_index > 4'd9) ? 4'd9 : cfg_i.filter_index;
  assign recip_prod = {34'd0, p1_step_q} * {33'd0, DIV10_RECIP};

  // stage control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_live_q <= 1'b0;
      p2_live_q <= 1'b0;
      p3_live_q <= 1'b0;
    end else begin
      p1_live_q <= live_i;
      p2_live_q <= p1_live_q;
      p3_live_q <= p2_live_q;
    end
  end

  // scale, then divide by ten and weight when a filter is selected
  always_ff @(posedge clk_i) begin
    p1_act_q  <= act_i;
    p1_key_q  <= key_i;
    p1_step_q <= ACC_W'(oct_step * STEP_SCALE);

    p2_act_q  <= p1_act_q;
    p2_filt_q <= filt_on;
    p2_step_q <= p1_step_q;
    p2_quot_q <= recip_prod[63:35];
    p2_wt_q   <= filter_weight(cfg_i.filt_sel == FILT_HIGH, row, p1_key_q);

    p3_act_q  <= p2_act_q;
    p3_step_q <= p2_filt_q ? ACC_W'({3'd0, p2_quot_q} * {28'd0, p2_wt_q}) : p2_step_q;
  end

  assign live_o = p3_live_q;
  assign act_o  = p3_act_q;
  assign step_o = p3_step_q;

endmodule

FILE: design/ppa_cell.sv
module ppa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      add_i,
  input  logic [ppa_pkg::ACC_W-1:0] step_i,
  input  logic [ppa_pkg::ACC_W-1:0] nb_acc_i,
  output logic [ppa_pkg::ACC_W-1:0] acc_o
);
  import ppa_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;

  // take the neighbor's phase, advanced by the step when add_i is set
  assign acc_d = add_i ? nb_acc_i + step_i : nb_acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: design/ppa_echo.sv
module ppa_echo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [ppa_pkg::SAMP_W-1:0] samp_i,
  output logic signed [ppa_pkg::TOT_W-1:0]  tot_o
);
  import ppa_pkg::*;

  logic signed [SAMP_W-1:0] line_q [ECHO_DEPTH];
  logic signed [TOT_W-1:0]  tot_q, tot_d;

  // weighted sum of the sample and the three taps before the shift
  assign tot_d = TOT_W'(samp_i) * 21'sd10
               + TOT_W'(line_q[TAP_A]) * 21'sd7
               + TOT_W'(line_q[TAP_B]) * 21'sd5
               + TOT_W'(line_q[TAP_C]) * 21'sd2;

  // delay line, entries zero and one both take the new sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ECHO_DEPTH; i++) begin
        line_q[i] <= '0;
      end
    end else if (en_i) begin
      line_q[0] <= samp_i;
      line_q[1] <= samp_i;
      for (int i = 2; i < ECHO_DEPTH; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tot_q <= tot_d;
    end
  end

  assign tot_o = tot_q;

endmodule

FILE: design/polyphonic_phase_accumulator_synth.sv
// one sample at a time: the block is busy from an input transfer until its output register is loaded, and
//   the next input transfer is taken the cycle after the output register is loaded
// a waiting output holds the sequencer in its last step until it is taken
// reset: phases and echo line clear to zero, registers to their defaults
module polyphonic_phase_accumulator_synth (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [11:0]                 key_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  dac_value_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ppa_pkg::*;

  cfg_t             cfg;
  logic             busy_q;
  logic [CYC_W-1:0] cyc_q;
  logic [11:0]      rem_q;
  logic             in_xfer, out_free, fire, hold;
  logic             issue_live, issue_act;
  logic [KEY_W-1:0] issue_key;
  logic             st_live, st_act;
  logic [ACC_W-1:0] st_step;
  logic [ACC_W-1:0] acc [NUM_KEYS];
  logic             act_d_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SAMP_W-1:0] v_q, v_d, s16;
  logic signed [SUM_W-1:0]  s;
  logic [4:0]               vol_c;
  logic [3:0]               sh;
  logic                     echo_en;
  logic signed [TOT_W-1:0]  tot;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       quot_prod;
  logic [QUOT_W-1:0]        quot_q;
  logic                     neg_q;
  logic signed [21:0]       w;
  logic [7:0]               dac_q;
  logic                     out_valid_q;

  ppa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  assign in_xfer    = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = busy_q && (cyc_q == CYC_W'(EV_LAST)) && out_free;
  assign hold       = (cyc_q == CYC_W'(EV_LAST)) && !out_free;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cyc_q  <= '0;
    end else if (in_xfer) begin
      busy_q <= 1'b1;
      cyc_q  <= '0;
    end else if (fire) begin
      busy_q <= 1'b0;
    end else if (busy_q && !hold) begin
      cyc_q <= cyc_q + CYC_W'(1);
    end
  end

  // key scan: lowest held key goes to the next slot
  assign issue_live = busy_q && (cyc_q < CYC_W'(NUM_KEYS));
  assign issue_act  = (rem_q != 12'd0);
  always_comb begin
    issue_key = '0;
    for (int k = 11; k >= 0; k--) begin
      if (rem_q[k]) begin
        issue_key = KEY_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rem_q <= key_mask_i & KEY_LIMIT_MASK;
    end else if (issue_live) begin
      rem_q <= rem_q & (rem_q - 12'd1);
    end
  end

  ppa_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .live_i (issue_live),
    .act_i  (issue_act),
    .key_i  (issue_key),
    .live_o (st_live),
    .act_o  (st_act),
    .step_o (st_step)
  );

  // ring of phase cells, the head wraps to the tail and is advanced there when a key is active
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
    if (i == NUM_KEYS - 1) begin : g_tail
      ppa_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (st_live),
        .add_i    (st_act),
        .step_i   (st_step),
        .nb_acc_i (acc[0]),
        .acc_o    (acc[i])
      );
    end else begin : g_body
      ppa_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (st_live),
        .add_i    (1'b0),
        .step_i   ('0),
        .nb_acc_i (acc[i+1]),
        .acc_o    (acc[i])
      );
    end
  end

  // sum of signed top bytes of the advanced slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_d_q <= 1'b0;
    end else begin
      act_d_q <= st_live && st_act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sum_q <= '0;
    end else if (act_d_q) begin
      sum_q <= sum_q + SUM_W'($signed(acc[NUM_KEYS-1][ACC_W-1:ACC_W-8]));
    end
  end

  // volume shift and waveform shaping
  assign vol_c = (cfg.volume > 5'd16) ? 5'd16 : cfg.volume;
  assign sh    = 4'd8 - vol_c[4:1];
  assign s     = sum_q >>> sh;
  assign s16   = SAMP_W'(s);

  always_comb begin
    case (cfg.waveform)
      WAVE_TRI: v_d = (sum_q < 0) ? 16'sd128 + (s16 <<< 2) : 16'sd127 - (s16 <<< 2);
      WAVE_SQR: v_d = (s > 0) ? (16'sd127 >>> sh) : (-16'sd128 >>> sh);
      default:  v_d = s16;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cyc_q == CYC_W'(EV_SHAPE)) begin
      v_q <= v_d;
    end
  end

  // echo line
  assign echo_en = busy_q && (cyc_q == CYC_W'(EV_ECHO)) && cfg.reverb_on;

  ppa_echo u_echo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (echo_en),
    .samp_i (v_q),
    .tot_o  (tot)
  );

  // divide the echo sum by ten, truncated toward zero
  assign mag       = (tot < 0) ? MAG_W'(-tot) : MAG_W'(tot);
  assign quot_prod = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, TOT_RECIP};

  always_ff @(posedge clk_i) begin
    if (cyc_q == CYC_W'(EV_DIVIDE)) begin
      quot_q <= quot_prod[23 +: QUOT_W];
      neg_q  <= tot < 0;
    end
  end

  // offset and saturate
  always_comb begin
    if (cfg.reverb_on) begin
      w = neg_q ? -$signed({5'd0, quot_q}) : $signed({5'd0, quot_q});
    end else begin
      w = 22'(v_q);
    end
    if (cfg.waveform != WAVE_TRI) begin
      w = w + 22'sd128;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (w < 0) begin
        dac_q <= 8'd0;
      end else if (w > 22'sd255) begin
        dac_q <= 8'd255;
      end else begin
        dac_q <= w[7:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_value_o = dac_q;

endmodule

FILE: design/ppa_checker.sv
module ppa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [7:0]                  dac_value_o
);

  // an input transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a new result appears only while an item is being worked on
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in flight");

  // finishing an item always leaves a result waiting
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("item finished without a result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(dac_value_o)))
    else $error("stalled result changed");

endmodule

bind polyphonic_phase_accumulator_synth ppa_checker u_ppa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .dac_value_o (dac_value_o)
);
